@@ sv/dll_pkg.sv @@
// Shared types, command codes and sizing constants for the linked list engine.
// No dependencies; imported by every module of the engine.
package dll_pkg;

   localparam int NODES_DEF = 64;
   localparam int CNT_W     = 7;

   localparam logic [3:0] CMD_CLEAR      = 4'd0;
   localparam logic [3:0] CMD_INS_FIRST  = 4'd1;
   localparam logic [3:0] CMD_INS_LAST   = 4'd2;
   localparam logic [3:0] CMD_CUR_FIRST  = 4'd3;
   localparam logic [3:0] CMD_CUR_LAST   = 4'd4;
   localparam logic [3:0] CMD_DEL_FIRST  = 4'd5;
   localparam logic [3:0] CMD_DEL_LAST   = 4'd6;
   localparam logic [3:0] CMD_DEL_AFTER  = 4'd7;
   localparam logic [3:0] CMD_DEL_BEFORE = 4'd8;
   localparam logic [3:0] CMD_INS_AFTER  = 4'd9;
   localparam logic [3:0] CMD_INS_BEFORE = 4'd10;
   localparam logic [3:0] CMD_UPDATE     = 4'd11;
   localparam logic [3:0] CMD_NEXT       = 4'd12;
   localparam logic [3:0] CMD_PREV       = 4'd13;
   localparam logic [3:0] CMD_REPORT     = 4'd14;

   typedef struct packed {
      logic [3:0]         cmd;
      logic signed [31:0] new_value;
   } req_type;

   typedef struct packed {
      logic               status;
      logic               is_empty;
      logic               is_active;
      logic signed [31:0] first_value;
      logic signed [31:0] last_value;
      logic signed [31:0] active_value;
      logic [CNT_W-1:0]   node_count;
   } rsp_type;

   // controller -> datapath strobes and result flags
   typedef struct packed {
      logic req_load;
      logic lrd_en;
      logic vrd_en;
      logic nwr_en;
      logic pwr_en;
      logic vwr_en;
      logic cap_first;
      logic cap_last;
      logic first_zero;
      logic last_zero;
      logic active_zero;
      logic rsp_load;
      logic status;
      logic is_empty;
      logic is_active;
   } dp_ctl_type;

endpackage

@@ sv/dll_datapath.sv @@
// Node memories (values, next links, prev links) and the result register.
// Depends on dll_pkg; driven by dll_ctrl.
module dll_datapath #(
   parameter int NODES = dll_pkg::NODES_DEF,
   parameter int IW    = $clog2(NODES + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dll_pkg::req_type           req_data,
   input  dll_pkg::dp_ctl_type        ctl,
   input  logic [IW-1:0]              lrd_addr,
   input  logic [IW-1:0]              vrd_addr,
   input  logic [IW-1:0]              nwr_addr,
   input  logic [IW-1:0]              nwr_data,
   input  logic [IW-1:0]              pwr_addr,
   input  logic [IW-1:0]              pwr_data,
   input  logic [IW-1:0]              vwr_addr,
   input  logic [dll_pkg::CNT_W-1:0]  node_count,
   output logic [IW-1:0]              lrd_nxt,
   output logic [IW-1:0]              lrd_prv,
   output logic                       rsp_free,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output dll_pkg::rsp_type           rsp_data
);
   import dll_pkg::*;

   localparam int AW = $clog2(NODES);

   logic [IW-1:0]      mem_n [NODES];
   logic [IW-1:0]      mem_p [NODES];
   logic signed [31:0] mem_v [NODES];

   logic signed [31:0] value_ff;
   logic [IW-1:0]      lrd_nxt_ff, lrd_prv_ff;
   logic signed [31:0] vrd_ff;
   logic signed [31:0] first_ff, last_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.req_load) value_ff <= req_data.new_value;
      if (ctl.nwr_en) mem_n[nwr_addr[AW-1:0]] <= nwr_data;
      if (ctl.pwr_en) mem_p[pwr_addr[AW-1:0]] <= pwr_data;
      if (ctl.vwr_en) mem_v[vwr_addr[AW-1:0]] <= value_ff;
      if (ctl.lrd_en) begin
         lrd_nxt_ff <= mem_n[lrd_addr[AW-1:0]];
         lrd_prv_ff <= mem_p[lrd_addr[AW-1:0]];
      end
      if (ctl.vrd_en) vrd_ff <= mem_v[vrd_addr[AW-1:0]];
      if (ctl.cap_first) first_ff <= ctl.first_zero ? 32'sd0 : vrd_ff;
      if (ctl.cap_last) last_ff <= ctl.last_zero ? 32'sd0 : vrd_ff;
      if (ctl.rsp_load) begin
         rsp_data_ff.status       <= ctl.status;
         rsp_data_ff.is_empty     <= ctl.is_empty;
         rsp_data_ff.is_active    <= ctl.is_active;
         rsp_data_ff.first_value  <= first_ff;
         rsp_data_ff.last_value   <= last_ff;
         rsp_data_ff.active_value <= ctl.active_zero ? 32'sd0 : vrd_ff;
         rsp_data_ff.node_count   <= node_count;
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   assign lrd_nxt   = lrd_nxt_ff;
   assign lrd_prv   = lrd_prv_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sv/dll_ctrl.sv @@
// Command sequencer: list pointers, free chain, node allocation and the
// per-command read/write schedule. Depends on dll_pkg; drives dll_datapath.
module dll_ctrl #(
   parameter int NODES = dll_pkg::NODES_DEF,
   parameter int IW    = $clog2(NODES + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [3:0]                 req_cmd,
   output logic                       idle,
   output dll_pkg::dp_ctl_type        ctl,
   output logic [IW-1:0]              lrd_addr,
   output logic [IW-1:0]              vrd_addr,
   output logic [IW-1:0]              nwr_addr,
   output logic [IW-1:0]              nwr_data,
   output logic [IW-1:0]              pwr_addr,
   output logic [IW-1:0]              pwr_data,
   output logic [IW-1:0]              vwr_addr,
   output logic [dll_pkg::CNT_W-1:0]  node_count,
   input  logic [IW-1:0]              lrd_nxt,
   input  logic [IW-1:0]              lrd_prv,
   input  logic                       rsp_free
);
   import dll_pkg::*;

   localparam logic [IW-1:0] NIL = IW'(NODES);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RDA  = 4'd1;
   localparam logic [3:0] ST_RDB  = 4'd2;
   localparam logic [3:0] ST_WR1  = 4'd3;
   localparam logic [3:0] ST_WR2  = 4'd4;
   localparam logic [3:0] ST_VH   = 4'd5;
   localparam logic [3:0] ST_VT   = 4'd6;
   localparam logic [3:0] ST_VC   = 4'd7;
   localparam logic [3:0] ST_CAP  = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [3:0]    cmd_ff, cmd_in;
   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [IW-1:0] free_ff, free_in, fresh_ff, fresh_in, count_ff, count_in;
   logic [IW-1:0] node_ff, node_in, keep_ff, keep_in;
   logic [IW-1:0] a_nxt_ff, a_nxt_in, a_prv_ff, a_prv_in;
   logic          full_ff, full_in, del_ff, del_in;
   logic          h_ok, t_ok, c_ok, f_ok, n_ok;

   assign h_ok = head_ff != NIL;
   assign t_ok = tail_ff != NIL;
   assign c_ok = cur_ff != NIL;
   assign f_ok = free_ff != NIL;
   assign n_ok = node_ff != NIL;

   always_comb begin
      state_in = state_ff;  cmd_in = cmd_ff;
      head_in = head_ff;    tail_in = tail_ff;   cur_in = cur_ff;
      free_in = free_ff;    fresh_in = fresh_ff; count_in = count_ff;
      node_in = node_ff;    keep_in = keep_ff;
      a_nxt_in = a_nxt_ff;  a_prv_in = a_prv_ff;
      full_in = full_ff;    del_in = del_ff;
      ctl = '0;
      lrd_addr = NIL; vrd_addr = NIL;
      nwr_addr = NIL; nwr_data = NIL;
      pwr_addr = NIL; pwr_data = NIL;
      vwr_addr = NIL;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in       = req_cmd;
               ctl.req_load = 1'b1;
               node_in      = NIL;
               full_in      = 1'b0;
               del_in       = 1'b0;
               state_in     = ST_RDA;
            end
         end
         ST_RDA: begin
            if (cmd_ff inside {CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AFTER, CMD_INS_BEFORE})
               lrd_addr = free_ff;
            else if (cmd_ff == CMD_DEL_FIRST)
               lrd_addr = head_ff;
            else if (cmd_ff == CMD_DEL_LAST)
               lrd_addr = tail_ff;
            else if (cmd_ff inside {CMD_DEL_AFTER, CMD_DEL_BEFORE, CMD_NEXT, CMD_PREV})
               lrd_addr = cur_ff;
            ctl.lrd_en = lrd_addr != NIL;
            state_in   = ST_RDB;
         end
         ST_RDB: begin
            a_nxt_in = lrd_nxt;
            a_prv_in = lrd_prv;
            // node allocation: free chain first, then never-used region
            if ((cmd_ff inside {CMD_INS_FIRST, CMD_INS_LAST}) ||
                ((cmd_ff inside {CMD_INS_AFTER, CMD_INS_BEFORE}) && c_ok)) begin
               if (f_ok) begin
                  node_in = free_ff;
                  free_in = lrd_nxt;
               end else if (fresh_ff != NIL) begin
                  node_in  = fresh_ff;
                  fresh_in = fresh_ff + 1'b1;
               end else begin
                  full_in = 1'b1;
               end
            end
            case (cmd_ff)
               CMD_DEL_AFTER: begin
                  lrd_addr   = lrd_nxt;
                  ctl.lrd_en = c_ok && (cur_ff != tail_ff);
               end
               CMD_DEL_BEFORE: begin
                  lrd_addr   = lrd_prv;
                  ctl.lrd_en = c_ok && (cur_ff != head_ff);
               end
               CMD_INS_AFTER, CMD_INS_BEFORE: begin
                  lrd_addr   = cur_ff;
                  ctl.lrd_en = c_ok;
               end
               default: ;
            endcase
            state_in = ST_WR1;
         end
         ST_WR1: begin
            case (cmd_ff)
               CMD_CLEAR: begin
                  if (h_ok) begin
                     ctl.nwr_en = 1'b1; nwr_addr = tail_ff; nwr_data = free_ff;
                     free_in = head_ff;
                  end
                  head_in = NIL; tail_in = NIL; cur_in = NIL;
                  count_in = '0;
               end
               CMD_INS_FIRST: begin
                  if (n_ok) begin
                     ctl.vwr_en = 1'b1; vwr_addr = node_ff;
                     ctl.nwr_en = 1'b1; nwr_addr = node_ff; nwr_data = head_ff;
                     if (h_ok) begin
                        ctl.pwr_en = 1'b1; pwr_addr = head_ff; pwr_data = node_ff;
                     end else tail_in = node_ff;
                  end
               end
               CMD_INS_LAST: begin
                  if (n_ok) begin
                     ctl.vwr_en = 1'b1; vwr_addr = node_ff;
                     ctl.pwr_en = 1'b1; pwr_addr = node_ff; pwr_data = tail_ff;
                     if (t_ok) begin
                        ctl.nwr_en = 1'b1; nwr_addr = tail_ff; nwr_data = node_ff;
                     end else head_in = node_ff;
                  end
               end
               CMD_CUR_FIRST: cur_in = head_ff;
               CMD_CUR_LAST:  cur_in = tail_ff;
               CMD_DEL_FIRST: begin
                  if (h_ok) begin
                     del_in = 1'b1; keep_in = head_ff;
                     if (cur_ff == head_ff) cur_in = NIL;
                     head_in = a_nxt_ff;
                     if (a_nxt_ff != NIL) begin
                        ctl.pwr_en = 1'b1; pwr_addr = a_nxt_ff; pwr_data = NIL;
                     end else tail_in = NIL;
                  end
               end
               CMD_DEL_LAST: begin
                  if (t_ok) begin
                     del_in = 1'b1; keep_in = tail_ff;
                     if (cur_ff == tail_ff) cur_in = NIL;
                     tail_in = a_prv_ff;
                     if (a_prv_ff != NIL) begin
                        ctl.nwr_en = 1'b1; nwr_addr = a_prv_ff; nwr_data = NIL;
                     end else head_in = NIL;
                  end
               end
               CMD_DEL_AFTER: begin
                  if (c_ok && (cur_ff != tail_ff)) begin
                     del_in = 1'b1; keep_in = a_nxt_ff;
                     ctl.nwr_en = 1'b1; nwr_addr = cur_ff; nwr_data = lrd_nxt;
                     if (a_nxt_ff == tail_ff) tail_in = cur_ff;
                     else begin
                        ctl.pwr_en = 1'b1; pwr_addr = lrd_nxt; pwr_data = cur_ff;
                     end
                  end
               end
               CMD_DEL_BEFORE: begin
                  if (c_ok && (cur_ff != head_ff)) begin
                     del_in = 1'b1; keep_in = a_prv_ff;
                     ctl.pwr_en = 1'b1; pwr_addr = cur_ff; pwr_data = lrd_prv;
                     if (a_prv_ff == head_ff) head_in = cur_ff;
                     else begin
                        ctl.nwr_en = 1'b1; nwr_addr = lrd_prv; nwr_data = cur_ff;
                     end
                  end
               end
               CMD_INS_AFTER: begin
                  if (n_ok) begin
                     ctl.vwr_en = 1'b1; vwr_addr = node_ff;
                     ctl.nwr_en = 1'b1; nwr_addr = node_ff; nwr_data = lrd_nxt;
                     ctl.pwr_en = 1'b1; pwr_addr = node_ff; pwr_data = cur_ff;
                     keep_in = lrd_nxt;
                  end
               end
               CMD_INS_BEFORE: begin
                  if (n_ok) begin
                     ctl.vwr_en = 1'b1; vwr_addr = node_ff;
                     ctl.pwr_en = 1'b1; pwr_addr = node_ff; pwr_data = lrd_prv;
                     ctl.nwr_en = 1'b1; nwr_addr = node_ff; nwr_data = cur_ff;
                     keep_in = lrd_prv;
                  end
               end
               CMD_UPDATE: begin
                  if (c_ok) begin
                     ctl.vwr_en = 1'b1; vwr_addr = cur_ff;
                  end
               end
               CMD_NEXT: if (c_ok) cur_in = a_nxt_ff;
               CMD_PREV: if (c_ok) cur_in = a_prv_ff;
               default: ;
            endcase
            state_in = ST_WR2;
         end
         ST_WR2: begin
            // freed node goes onto the free chain
            if (del_ff) begin
               ctl.nwr_en = 1'b1; nwr_addr = keep_ff; nwr_data = free_ff;
               free_in = keep_ff;
               if (count_ff != '0) count_in = count_ff - 1'b1;
            end
            if (n_ok) count_in = count_ff + 1'b1;
            case (cmd_ff)
               CMD_INS_FIRST: begin
                  if (n_ok) begin
                     ctl.pwr_en = 1'b1; pwr_addr = node_ff; pwr_data = NIL;
                     head_in = node_ff;
                  end
               end
               CMD_INS_LAST: begin
                  if (n_ok) begin
                     ctl.nwr_en = 1'b1; nwr_addr = node_ff; nwr_data = NIL;
                     tail_in = node_ff;
                  end
               end
               CMD_INS_AFTER: begin
                  if (n_ok) begin
                     ctl.nwr_en = 1'b1; nwr_addr = cur_ff; nwr_data = node_ff;
                     if (cur_ff == tail_ff) tail_in = node_ff;
                     else begin
                        ctl.pwr_en = 1'b1; pwr_addr = keep_ff; pwr_data = node_ff;
                     end
                  end
               end
               CMD_INS_BEFORE: begin
                  if (n_ok) begin
                     ctl.pwr_en = 1'b1; pwr_addr = cur_ff; pwr_data = node_ff;
                     if (cur_ff == head_ff) head_in = node_ff;
                     else begin
                        ctl.nwr_en = 1'b1; nwr_addr = keep_ff; nwr_data = node_ff;
                     end
                  end
               end
               default: ;
            endcase
            state_in = ST_VH;
         end
         ST_VH: begin
            vrd_addr = head_ff; ctl.vrd_en = h_ok;
            state_in = ST_VT;
         end
         ST_VT: begin
            ctl.cap_first = 1'b1; ctl.first_zero = !h_ok;
            vrd_addr = tail_ff; ctl.vrd_en = t_ok;
            state_in = ST_VC;
         end
         ST_VC: begin
            ctl.cap_last = 1'b1; ctl.last_zero = !t_ok;
            vrd_addr = cur_ff; ctl.vrd_en = c_ok;
            state_in = ST_CAP;
         end
         ST_CAP: begin
            if (rsp_free) begin
               ctl.rsp_load    = 1'b1;
               ctl.active_zero = !c_ok;
               ctl.status      = full_ff;
               ctl.is_empty    = !h_ok;
               ctl.is_active   = c_ok;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= NIL;
         tail_ff  <= NIL;
         cur_ff   <= NIL;
         free_ff  <= NIL;
         fresh_ff <= '0;
         count_ff <= '0;
         node_ff  <= NIL;
         full_ff  <= 1'b0;
         del_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         cur_ff   <= cur_in;
         free_ff  <= free_in;
         fresh_ff <= fresh_in;
         count_ff <= count_in;
         node_ff  <= node_in;
         full_ff  <= full_in;
         del_ff   <= del_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      keep_ff  <= keep_in;
      a_nxt_ff <= a_nxt_in;
      a_prv_ff <= a_prv_in;
   end

   assign idle       = state_ff == ST_IDLE;
   assign node_count = CNT_W'(count_ff);

endmodule

@@ sv/doubly_linked_list_engine_core.sv @@
// Doubly linked list engine: top level joining sequencer and node memories.
// A command steps from accepted beat to result beat through accept, 2 link reads,
// 2 link/value writes, 3 value reads of first/last/active and result load, which
// waits while an earlier result is stalled. Commands are taken one at a time.
// Reset (synchronous, active high) empties the list and result register.
module doubly_linked_list_engine_core #(
   parameter int NODES = dll_pkg::NODES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dll_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dll_pkg::rsp_type  rsp_data
);
   import dll_pkg::*;

   // pointer width holds every node index plus the null code (NODES)
   localparam int IW = $clog2(NODES + 1);

   dp_ctl_type       ctl;
   logic             idle;
   logic [IW-1:0]    lrd_addr, vrd_addr, nwr_addr, nwr_data;
   logic [IW-1:0]    pwr_addr, pwr_data, vwr_addr, lrd_nxt, lrd_prv;
   logic [CNT_W-1:0] node_count;
   logic             rsp_free;

   // one beat at a time: input held off until the sequencer returns to idle;
   // the result register lets the next beat enter while a result waits
   assign req_stall = !idle;

   dll_ctrl #(.NODES(NODES), .IW(IW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_cmd    (req_data.cmd),
      .idle       (idle),
      .ctl        (ctl),
      .lrd_addr   (lrd_addr),
      .vrd_addr   (vrd_addr),
      .nwr_addr   (nwr_addr),
      .nwr_data   (nwr_data),
      .pwr_addr   (pwr_addr),
      .pwr_data   (pwr_data),
      .vwr_addr   (vwr_addr),
      .node_count (node_count),
      .lrd_nxt    (lrd_nxt),
      .lrd_prv    (lrd_prv),
      .rsp_free   (rsp_free)
   );

   dll_datapath #(.NODES(NODES), .IW(IW)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .ctl        (ctl),
      .lrd_addr   (lrd_addr),
      .vrd_addr   (vrd_addr),
      .nwr_addr   (nwr_addr),
      .nwr_data   (nwr_data),
      .pwr_addr   (pwr_addr),
      .pwr_data   (pwr_data),
      .vwr_addr   (vwr_addr),
      .node_count (node_count),
      .lrd_nxt    (lrd_nxt),
      .lrd_prv    (lrd_prv),
      .rsp_free   (rsp_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

@@ sv/dll_checker.sv @@
// Port-level checks for the linked list engine, bound to the top level.
// Depends on dll_pkg and doubly_linked_list_engine_core.
module dll_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dll_pkg::rsp_type  rsp_data
);
   import dll_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second beat taken while command in flight");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |-> rsp_data.node_count == '0 &&
      rsp_data.first_value == 32'sd0 && rsp_data.last_value == 32'sd0 &&
      !rsp_data.is_active)
      else $error("empty list reports contents");

   a_inactive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_active |-> rsp_data.active_value == 32'sd0)
      else $error("inactive cursor reports a value");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind doubly_linked_list_engine_core dll_checker u_dll_checker (.*);
